FILE: design/trld_pkg.sv
// shared types, constants and helpers of the tile run-length decoder
package trld_pkg;

  localparam int TBL_DEPTH       = 240;
  localparam int TBL_AW          = 8;
  localparam int ROW_SLOTS       = 15;
  localparam int CODED_SLOTS     = 5;
  localparam int RUN_W           = 15;
  localparam int MAX_TILE_PIXELS = 32385;

  localparam logic [RUN_W-1:0] RUN_SAT  = '1;
  localparam logic [RUN_W-1:0] SIZE_CAP = RUN_W'(MAX_TILE_PIXELS);

  // configuration register indexes
  localparam logic [1:0] CFG_TILE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_TILE_HEIGHT = 2'd1;

  // tile header codes
  localparam logic [1:0] HDR_END   = 2'd0;
  localparam logic [1:0] HDR_HORIZ = 2'd1;
  localparam logic [1:0] HDR_VERT  = 2'd2;
  localparam logic [1:0] HDR_RAW   = 2'd3;

  localparam logic [1:0] MODE_NONE = 2'd0;

  typedef enum logic [3:0] {
    PH_TABLE,
    PH_FILL,
    PH_HEADER,
    PH_RAW,
    PH_FIRST,
    PH_LEN_A,
    PH_LEN_B,
    PH_LEN_EXT,
    PH_SEL,
    PH_NEAR,
    PH_FAR3,
    PH_FAR4,
    PH_LOOKUP,
    PH_DONE
  } phase_t;

  // table entry of (row, slot), slots numbered 1..15
  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [3:0] row, input logic [3:0] slot);
    logic [TBL_AW-1:0] base;
    base = {row, 4'b0000} - {4'b0000, row};
    return base + {4'b0000, slot} - TBL_AW'(1);
  endfunction

endpackage

FILE: design/tile_run_length_decoder_top.sv
// tile run-length decoder: bit-serial stream in, one run per completed code out
//
// Input: one compressed stream bit per request (in_valid / in_stall), LSB first in
// each colour or length nibble. Output: one run per request (out_valid / out_stall) with its colour,
// pixel count, tile mode and first/last/end markers. Tile size comes from the
// cfg_ port (index 0 tile_width, index 1 tile_height), written while idle, and is
// latched at each tile header.
// A result appears in the output register in the cycle after the bit that
// completes its code. One bit is taken per cycle, except that:
//  - after the fifth coded colour of each table row the unused colours are written
//    to the neighbour table RAM, one slot per cycle, with in_stall high;
//  - each relative colour code adds a PH_LOOKUP stall for the registered RAM read.
// in_stall is also high while a result waits in the output register and the
// receiver stalls; nothing is dropped. Synchronous reset restarts the table load
// and sets both tile sizes to 8. After the end header all bits are taken and
// ignored until reset.
module tile_run_length_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_stream_bit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_color,
  output logic [14:0] out_run_pixels,
  output logic [1:0]  out_tile_mode,
  output logic        out_first_of_tile,
  output logic        out_last_of_tile,
  output logic        out_end_of_stream,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_data
);

  localparam int RW = trld_pkg::RUN_W;

  trld_pkg::phase_t state_r, state_nxt;

  logic [6:0]    tile_width_r;
  logic [7:0]    tile_height_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic [3:0]    acc_r, acc_nxt;
  logic [RW-1:0] len_r, len_nxt;
  logic [3:0]    row_r, row_nxt;
  logic [3:0]    slot_r, slot_nxt;
  logic [3:0]    k_r, k_nxt;
  logic [15:0]   marks_r, marks_nxt;
  logic [3:0]    prev_r, prev_nxt;
  logic [RW-1:0] pl_r, pl_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic          tile_start_r, tile_start_nxt;
  logic          done_r, done_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [3:0]    out_color_r, out_color_nxt;
  logic [RW-1:0] out_run_r, out_run_nxt;
  logic [1:0]    out_mode_r, out_mode_nxt;
  logic          out_first_r, out_first_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_end_r, out_end_nxt;

  logic [3:0] mem [trld_pkg::TBL_DEPTH];
  logic [3:0] rd_q;
  logic                      mem_we, mem_re;
  logic [trld_pkg::TBL_AW-1:0] mem_waddr, mem_raddr;
  logic [3:0]                mem_wdata;

  logic          in_acc;
  logic          bit_in;
  logic          nib_done;
  logic [3:0]    nib;
  logic [1:0]    hdr;
  logic [2:0]    far_v;
  logic [RW:0]   ext_sum;
  logic [RW-1:0] cand_len, clip_len, pl_after;
  logic          run_last;
  logic [RW-1:0] tile_prod, tile_size;
  logic [RW-1:0] raw_pl;
  logic [15:0]   fill_marks;
  logic [3:0]    fill_pick;

  assign in_stall  = (state_r == trld_pkg::PH_FILL) || (state_r == trld_pkg::PH_LOOKUP) ||
                     (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign bit_in    = in_stream_bit;
  assign cfg_ready = 1'b1;

  assign nib_done = (cnt_r == 2'd3);
  assign nib      = {bit_in, acc_r[3:1]};
  assign hdr      = {bit_in, acc_r[0]};
  assign far_v    = {acc_r[1:0], bit_in};

  // candidate run length for the code finishing on this bit
  assign ext_sum = {1'b0, len_r} + {{(RW-3){1'b0}}, nib};
  always_comb begin
    case (state_r)
      trld_pkg::PH_LEN_A: cand_len = RW'(1);
      trld_pkg::PH_LEN_B: cand_len = RW'(2);
      default:            cand_len = ext_sum[RW] ? trld_pkg::RUN_SAT : ext_sum[RW-1:0];
    endcase
  end
  assign clip_len = (cand_len > pl_r) ? pl_r : cand_len;
  assign pl_after = pl_r - clip_len;
  assign run_last = (pl_after == '0);

  assign raw_pl = (pl_r != '0) ? pl_r - RW'(1) : pl_r;

  assign tile_prod = RW'({8'b0, tile_width_r} * {7'b0, tile_height_r});
  always_comb begin
    if (tile_prod == '0) begin
      tile_size = RW'(1);
    end else if (tile_prod > trld_pkg::SIZE_CAP) begin
      tile_size = trld_pkg::SIZE_CAP;
    end else begin
      tile_size = tile_prod;
    end
  end

  // highest colour in 1..k not used by the row, else 0
  assign fill_marks = marks_r | (16'd1 << row_r);
  always_comb begin
    fill_pick = 4'd0;
    for (int j = 1; j < 16; j++) begin
      if (4'(j) <= k_r && !fill_marks[j]) begin
        fill_pick = 4'(j);
      end
    end
  end

  // next phase
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      trld_pkg::PH_TABLE: begin
        if (in_acc && nib_done && slot_r == 4'(trld_pkg::CODED_SLOTS)) begin
          state_nxt = trld_pkg::PH_FILL;
        end
      end
      trld_pkg::PH_FILL: begin
        if (slot_r == 4'(trld_pkg::ROW_SLOTS)) begin
          state_nxt = (row_r == 4'd15) ? trld_pkg::PH_HEADER : trld_pkg::PH_TABLE;
        end
      end
      trld_pkg::PH_HEADER: begin
        if (in_acc && cnt_r[0]) begin
          unique case (hdr)
            trld_pkg::HDR_END:                     state_nxt = trld_pkg::PH_DONE;
            trld_pkg::HDR_RAW:                     state_nxt = trld_pkg::PH_RAW;
            trld_pkg::HDR_HORIZ, trld_pkg::HDR_VERT: state_nxt = trld_pkg::PH_FIRST;
            default:                               state_nxt = trld_pkg::PH_FIRST;
          endcase
        end
      end
      trld_pkg::PH_RAW: begin
        if (in_acc && nib_done && raw_pl == '0) begin
          state_nxt = trld_pkg::PH_HEADER;
        end
      end
      trld_pkg::PH_FIRST: begin
        if (in_acc && nib_done) begin
          state_nxt = trld_pkg::PH_LEN_A;
        end
      end
      trld_pkg::PH_LEN_A: begin
        if (in_acc) begin
          if (bit_in) begin
            state_nxt = trld_pkg::PH_LEN_B;
          end else begin
            state_nxt = run_last ? trld_pkg::PH_HEADER : trld_pkg::PH_SEL;
          end
        end
      end
      trld_pkg::PH_LEN_B: begin
        if (in_acc) begin
          if (bit_in) begin
            state_nxt = trld_pkg::PH_LEN_EXT;
          end else begin
            state_nxt = run_last ? trld_pkg::PH_HEADER : trld_pkg::PH_SEL;
          end
        end
      end
      trld_pkg::PH_LEN_EXT: begin
        if (in_acc && nib_done && nib != 4'hf) begin
          state_nxt = run_last ? trld_pkg::PH_HEADER : trld_pkg::PH_SEL;
        end
      end
      trld_pkg::PH_SEL: begin
        if (in_acc) begin
          state_nxt = bit_in ? trld_pkg::PH_FAR3 : trld_pkg::PH_NEAR;
        end
      end
      trld_pkg::PH_NEAR: begin
        if (in_acc) begin
          state_nxt = trld_pkg::PH_LOOKUP;
        end
      end
      trld_pkg::PH_FAR3: begin
        if (in_acc && cnt_r == 2'd2) begin
          state_nxt = (far_v < 3'd3) ? trld_pkg::PH_LOOKUP : trld_pkg::PH_FAR4;
        end
      end
      trld_pkg::PH_FAR4: begin
        if (in_acc) begin
          state_nxt = trld_pkg::PH_LOOKUP;
        end
      end
      trld_pkg::PH_LOOKUP: state_nxt = trld_pkg::PH_LEN_A;
      trld_pkg::PH_DONE:   state_nxt = trld_pkg::PH_DONE;
      default:             state_nxt = state_r;
    endcase
  end

  // datapath, table RAM controls and result register
  always_comb begin
    cnt_nxt        = cnt_r;
    acc_nxt        = acc_r;
    len_nxt        = len_r;
    row_nxt        = row_r;
    slot_nxt       = slot_r;
    k_nxt          = k_r;
    marks_nxt      = marks_r;
    prev_nxt       = prev_r;
    pl_nxt         = pl_r;
    mode_nxt       = mode_r;
    tile_start_nxt = tile_start_r;
    done_nxt       = done_r;
    mem_we         = 1'b0;
    mem_waddr      = trld_pkg::tbl_addr(row_r, slot_r);
    mem_wdata      = nib;
    mem_re         = 1'b0;
    mem_raddr      = trld_pkg::tbl_addr(prev_r, 4'd1);
    out_valid_nxt  = out_valid_r && out_stall;
    out_color_nxt  = out_color_r;
    out_run_nxt    = out_run_r;
    out_mode_nxt   = out_mode_r;
    out_first_nxt  = out_first_r;
    out_last_nxt   = out_last_r;
    out_end_nxt    = out_end_r;

    unique case (state_r)
      trld_pkg::PH_TABLE: begin
        if (in_acc) begin
          cnt_nxt = cnt_r + 2'd1;
          acc_nxt = nib;
          if (nib_done) begin
            mem_we    = 1'b1;
            marks_nxt = marks_r | (16'd1 << nib);
            acc_nxt   = 4'd0;
            if (slot_r == 4'(trld_pkg::CODED_SLOTS)) begin
              k_nxt = 4'd15;
            end
            slot_nxt = slot_r + 4'd1;
          end
        end
      end
      trld_pkg::PH_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = fill_pick;
        k_nxt     = (fill_pick != 4'd0) ? fill_pick - 4'd1 : 4'd0;
        slot_nxt  = slot_r + 4'd1;
        if (slot_r == 4'(trld_pkg::ROW_SLOTS)) begin
          marks_nxt = '0;
          slot_nxt  = 4'd1;
          row_nxt   = row_r + 4'd1;
        end
      end
      trld_pkg::PH_HEADER: begin
        if (in_acc) begin
          if (!cnt_r[0]) begin
            acc_nxt = {3'b000, bit_in};
            cnt_nxt = 2'd1;
          end else begin
            acc_nxt = 4'd0;
            cnt_nxt = 2'd0;
            if (hdr == trld_pkg::HDR_END) begin
              done_nxt      = 1'b1;
              out_valid_nxt = 1'b1;
              out_color_nxt = 4'd0;
              out_run_nxt   = '0;
              out_mode_nxt  = trld_pkg::MODE_NONE;
              out_first_nxt = 1'b0;
              out_last_nxt  = 1'b0;
              out_end_nxt   = 1'b1;
              tile_start_nxt = 1'b0;
            end else begin
              mode_nxt       = hdr - 2'd1;
              pl_nxt         = tile_size;
              tile_start_nxt = 1'b1;
            end
          end
        end
      end
      trld_pkg::PH_RAW: begin
        if (in_acc) begin
          cnt_nxt = cnt_r + 2'd1;
          acc_nxt = nib;
          if (nib_done) begin
            acc_nxt        = 4'd0;
            pl_nxt         = raw_pl;
            out_valid_nxt  = 1'b1;
            out_color_nxt  = nib;
            out_run_nxt    = RW'(1);
            out_mode_nxt   = mode_r;
            out_first_nxt  = tile_start_r;
            out_last_nxt   = (raw_pl == '0);
            out_end_nxt    = 1'b0;
            tile_start_nxt = 1'b0;
          end
        end
      end
      trld_pkg::PH_FIRST: begin
        if (in_acc) begin
          cnt_nxt = cnt_r + 2'd1;
          acc_nxt = nib;
          if (nib_done) begin
            prev_nxt = nib;
            acc_nxt  = 4'd0;
          end
        end
      end
      trld_pkg::PH_LEN_A, trld_pkg::PH_LEN_B, trld_pkg::PH_LEN_EXT: begin
        if (in_acc) begin
          if (state_r == trld_pkg::PH_LEN_EXT) begin
            cnt_nxt = cnt_r + 2'd1;
            acc_nxt = nib;
            if (nib_done) begin
              acc_nxt = 4'd0;
              len_nxt = cand_len;
            end
          end else if (state_r == trld_pkg::PH_LEN_B && bit_in) begin
            len_nxt = RW'(3);
            cnt_nxt = 2'd0;
            acc_nxt = 4'd0;
          end
          // a zero bit ends the short codes, a nibble other than 15 ends the long one
          if ((state_r != trld_pkg::PH_LEN_EXT && !bit_in) ||
              (state_r == trld_pkg::PH_LEN_EXT && nib_done && nib != 4'hf)) begin
            pl_nxt         = pl_after;
            cnt_nxt        = 2'd0;
            acc_nxt        = 4'd0;
            out_valid_nxt  = 1'b1;
            out_color_nxt  = prev_r;
            out_run_nxt    = clip_len;
            out_mode_nxt   = mode_r;
            out_first_nxt  = tile_start_r;
            out_last_nxt   = run_last;
            out_end_nxt    = 1'b0;
            tile_start_nxt = 1'b0;
          end
        end
      end
      trld_pkg::PH_SEL: begin
        if (in_acc) begin
          cnt_nxt = 2'd0;
          acc_nxt = 4'd0;
        end
      end
      trld_pkg::PH_NEAR: begin
        if (in_acc) begin
          mem_re    = 1'b1;
          mem_raddr = trld_pkg::tbl_addr(prev_r, {3'b000, bit_in} + 4'd1);
        end
      end
      trld_pkg::PH_FAR3: begin
        if (in_acc) begin
          acc_nxt = {acc_r[2:0], bit_in};
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_r == 2'd2) begin
            cnt_nxt = 2'd0;
            if (far_v < 3'd3) begin
              mem_re    = 1'b1;
              mem_raddr = trld_pkg::tbl_addr(prev_r, {1'b0, far_v} + 4'd3);
            end
          end
        end
      end
      trld_pkg::PH_FAR4: begin
        if (in_acc) begin
          mem_re    = 1'b1;
          mem_raddr = trld_pkg::tbl_addr(prev_r, {acc_r[2:0], bit_in});
        end
      end
      trld_pkg::PH_LOOKUP: begin
        prev_nxt = rd_q;
        cnt_nxt  = 2'd0;
        acc_nxt  = 4'd0;
      end
      trld_pkg::PH_DONE: begin
        done_nxt = 1'b1;
      end
      default: begin
        done_nxt = done_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_width_r  <= 7'd8;
      tile_height_r <= 8'd8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        trld_pkg::CFG_TILE_WIDTH:  tile_width_r  <= cfg_data[6:0];
        trld_pkg::CFG_TILE_HEIGHT: tile_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= trld_pkg::PH_TABLE;
      cnt_r        <= '0;
      acc_r        <= '0;
      len_r        <= '0;
      row_r        <= '0;
      slot_r       <= 4'd1;
      k_r          <= '0;
      marks_r      <= '0;
      prev_r       <= '0;
      pl_r         <= '0;
      mode_r       <= '0;
      tile_start_r <= 1'b0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      acc_r        <= acc_nxt;
      len_r        <= len_nxt;
      row_r        <= row_nxt;
      slot_r       <= slot_nxt;
      k_r          <= k_nxt;
      marks_r      <= marks_nxt;
      prev_r       <= prev_nxt;
      pl_r         <= pl_nxt;
      mode_r       <= mode_nxt;
      tile_start_r <= tile_start_nxt;
      done_r       <= done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_color_r <= out_color_nxt;
    out_run_r   <= out_run_nxt;
    out_mode_r  <= out_mode_nxt;
    out_first_r <= out_first_nxt;
    out_last_r  <= out_last_nxt;
    out_end_r   <= out_end_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_color         = out_color_r;
  assign out_run_pixels    = out_run_r;
  assign out_tile_mode     = out_mode_r;
  assign out_first_of_tile = out_first_r;
  assign out_last_of_tile  = out_last_r;
  assign out_end_of_stream = out_end_r;

  // once the end header is seen the decoder never leaves the done phase
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r && state_r == trld_pkg::PH_DONE)
    else $error("decoder left done phase");

  // a run other than the end marker always carries pixels
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_end_r |-> out_run_r != '0)
    else $error("empty run emitted");

  // a run that completes its tile leaves no pixels behind
  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_last_r |-> pl_r == '0)
    else $error("last run with pixels left");

  // the table RAM read always resolves in the next cycle
  a_lookup_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == trld_pkg::PH_LOOKUP |=> state_r == trld_pkg::PH_LEN_A)
    else $error("lookup wait not one cycle");

  // the unused-colour sweep ends on the last slot of a row
  a_fill_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == trld_pkg::PH_FILL && slot_r == 4'(trld_pkg::ROW_SLOTS) |=>
      slot_r == 4'd1 && marks_r == '0)
    else $error("fill sweep did not close the row");

endmodule
